FILE: rtl/rv32i_r_type_execute_macros.svh
// Assertion macros used by the execute unit top level.
`ifndef RV32I_R_TYPE_EXECUTE_MACROS_SVH
`define RV32I_R_TYPE_EXECUTE_MACROS_SVH

`ifndef ASSERT_OFF
`define RV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define RV_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RV_ASSERT(label, prop, msg)
`define RV_ASSERT_IMPL(label, ante, cons, msg)
`define RV_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/rv32r_pkg.sv
// Shared types and constants of the R-type execute unit.
package rv32r_pkg;

    localparam int XLEN       = 32;
    localparam int NUM_REGS   = 32;
    localparam int REG_AW     = 5;
    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    localparam logic [6:0] OPC_RTYPE = 7'h33;
    localparam logic [6:0] F7_ALT    = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    typedef enum logic [1:0] {
        OP_EXEC = 2'd0,
        OP_LOAD = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_rf_wr;

    typedef struct packed {
        logic [XLEN-1:0]   value;
        logic [REG_AW-1:0] dest;
        logic              wrote;
        logic              illegal;
    } t_result;

endpackage

FILE: rtl/rv32r_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rv32r_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rv32r_rf.sv
// Register file: two RAM banks, per-entry valid bits and write forwarding.
module rv32r_rf (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [rv32r_pkg::REG_AW-1:0]  i_raddr_a,
    input  logic [rv32r_pkg::REG_AW-1:0]  i_raddr_b,
    input  rv32r_pkg::t_rf_wr             i_wr,
    output logic [rv32r_pkg::XLEN-1:0]    o_rdata_a,
    output logic [rv32r_pkg::XLEN-1:0]    o_rdata_b
);

    logic [rv32r_pkg::XLEN-1:0]     w_ram_a;
    logic [rv32r_pkg::XLEN-1:0]     w_ram_b;
    logic [rv32r_pkg::NUM_REGS-1:0] r_valid;
    logic [rv32r_pkg::REG_AW-1:0]   r_addr_a;
    logic [rv32r_pkg::REG_AW-1:0]   r_addr_b;
    rv32r_pkg::t_rf_wr              r_fwd;

    rv32r_ram #(
        .WIDTH(rv32r_pkg::XLEN),
        .DEPTH(rv32r_pkg::NUM_REGS)
    ) u_bank_a (
        .i_clk  (i_clk),
        .i_we   (i_wr.en),
        .i_waddr(i_wr.addr),
        .i_wdata(i_wr.data),
        .i_re   (i_load),
        .i_raddr(i_raddr_a),
        .o_rdata(w_ram_a)
    );

    rv32r_ram #(
        .WIDTH(rv32r_pkg::XLEN),
        .DEPTH(rv32r_pkg::NUM_REGS)
    ) u_bank_b (
        .i_clk  (i_clk),
        .i_we   (i_wr.en),
        .i_waddr(i_wr.addr),
        .i_wdata(i_wr.data),
        .i_re   (i_load),
        .i_raddr(i_raddr_b),
        .o_rdata(w_ram_b)
    );

    // A write landing on the same edge as the read is not seen by the RAM,
    // so it is kept aside and forwarded to the operands of that item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_fwd.en <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_load) begin
                r_fwd.en <= i_wr.en;
            end
        end
        if (i_load) begin
            r_addr_a   <= i_raddr_a;
            r_addr_b   <= i_raddr_b;
            r_fwd.addr <= i_wr.addr;
            r_fwd.data <= i_wr.data;
        end
    end

    always_comb begin
        if (r_addr_a == '0) begin
            o_rdata_a = '0;
        end else if (r_fwd.en && r_fwd.addr == r_addr_a) begin
            o_rdata_a = r_fwd.data;
        end else if (r_valid[r_addr_a]) begin
            o_rdata_a = w_ram_a;
        end else begin
            o_rdata_a = '0;
        end

        if (r_addr_b == '0) begin
            o_rdata_b = '0;
        end else if (r_fwd.en && r_fwd.addr == r_addr_b) begin
            o_rdata_b = r_fwd.data;
        end else if (r_valid[r_addr_b]) begin
            o_rdata_b = w_ram_b;
        end else begin
            o_rdata_b = '0;
        end
    end

endmodule

FILE: rtl/rv32r_alu.sv
// Decode and execute of one operation: R-type ALU, register load and read.
module rv32r_alu (
    input  rv32r_pkg::t_op                i_op,
    input  logic [rv32r_pkg::XLEN-1:0]    i_instr,
    input  logic [rv32r_pkg::REG_AW-1:0]  i_reg_index,
    input  logic [rv32r_pkg::XLEN-1:0]    i_load_value,
    input  logic [rv32r_pkg::XLEN-1:0]    i_a,
    input  logic [rv32r_pkg::XLEN-1:0]    i_b,
    output rv32r_pkg::t_result            o_res,
    output rv32r_pkg::t_rf_wr             o_wr
);

    logic [6:0]                   w_opcode;
    logic [rv32r_pkg::REG_AW-1:0] w_rd;
    logic [2:0]                   w_f3;
    logic [6:0]                   w_f7;
    logic [4:0]                   w_sh;
    logic [rv32r_pkg::XLEN-1:0]   w_alu;
    logic                         w_ok;

    assign w_opcode = i_instr[6:0];
    assign w_rd     = i_instr[11:7];
    assign w_f3     = i_instr[14:12];
    assign w_f7     = i_instr[31:25];
    assign w_sh     = i_b[4:0];

    always_comb begin
        w_alu = '0;
        w_ok  = (w_opcode == rv32r_pkg::OPC_RTYPE);
        if (w_f7 == rv32r_pkg::F7_ALT) begin
            case (w_f3)
                rv32r_pkg::F3_ADD: w_alu = i_a - i_b;
                rv32r_pkg::F3_SRL: w_alu = $unsigned($signed(i_a) >>> w_sh);
                default:           w_ok  = 1'b0;
            endcase
        end else begin
            case (w_f3)
                rv32r_pkg::F3_ADD:  w_alu = i_a + i_b;
                rv32r_pkg::F3_SLL:  w_alu = i_a << w_sh;
                rv32r_pkg::F3_SLT:  w_alu = {31'd0, $signed(i_a) < $signed(i_b)};
                rv32r_pkg::F3_SLTU: w_alu = {31'd0, i_a < i_b};
                rv32r_pkg::F3_XOR:  w_alu = i_a ^ i_b;
                rv32r_pkg::F3_SRL:  w_alu = i_a >> w_sh;
                rv32r_pkg::F3_OR:   w_alu = i_a | i_b;
                default:            w_alu = i_a & i_b;
            endcase
        end
    end

    always_comb begin
        o_res = '0;
        o_wr  = '0;
        case (i_op)
            rv32r_pkg::OP_EXEC: begin
                if (w_ok) begin
                    o_res.value = w_alu;
                    o_res.dest  = w_rd;
                    o_res.wrote = (w_rd != '0);
                    o_wr.en     = (w_rd != '0);
                    o_wr.addr   = w_rd;
                    o_wr.data   = w_alu;
                end else begin
                    o_res.illegal = 1'b1;
                end
            end
            rv32r_pkg::OP_LOAD: begin
                if (i_reg_index != '0) begin
                    o_res.value = i_load_value;
                    o_res.dest  = i_reg_index;
                    o_res.wrote = 1'b1;
                    o_wr.en     = 1'b1;
                    o_wr.addr   = i_reg_index;
                    o_wr.data   = i_load_value;
                end
            end
            rv32r_pkg::OP_READ: begin
                o_res.value = i_a;
                o_res.dest  = i_reg_index;
            end
            default: begin
                o_res.illegal = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/rv32i_r_type_execute.sv
// Top level of the RV32I R-type execute unit with its own register file.
// An accepted input is held in the s1 register, then its result in the result register.
// Throughput: one operation per cycle while the result side keeps up.
// A register write is forwarded to an operand read on the same edge.
// Reset (synchronous, active low) empties the pipeline and marks all
// registers invalid, so they read as zero until written.
`include "rv32i_r_type_execute_macros.svh"

module rv32i_r_type_execute (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // instr_word[31:0], reg_index[36:32], load_value[68:37], zero pad
    input  logic [rv32r_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation[1:0]
    input  logic [rv32r_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // result_value[31:0], dest_index[36:32], zero pad
    output logic [rv32r_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // wrote_reg[0], illegal[1]
    output logic [rv32r_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

    logic                          s_fire;
    logic                          w_m_free;
    logic                          w_s1_adv;
    logic [rv32r_pkg::REG_AW-1:0]  w_raddr_a;
    logic [rv32r_pkg::REG_AW-1:0]  w_raddr_b;
    logic [rv32r_pkg::XLEN-1:0]    w_a;
    logic [rv32r_pkg::XLEN-1:0]    w_b;
    rv32r_pkg::t_result            w_res;
    rv32r_pkg::t_rf_wr             w_alu_wr;
    rv32r_pkg::t_rf_wr             w_wr;

    logic                          r_s1_valid;
    rv32r_pkg::t_op                r_s1_op;
    logic [rv32r_pkg::XLEN-1:0]    r_s1_instr;
    logic [rv32r_pkg::REG_AW-1:0]  r_s1_idx;
    logic [rv32r_pkg::XLEN-1:0]    r_s1_lval;
    logic                          r_m_valid;
    rv32r_pkg::t_result            r_m_res;

    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign w_m_free      = !r_m_valid || m_axis_tready;
    assign w_s1_adv      = r_s1_valid && w_m_free;
    assign s_axis_tready = !r_s1_valid || w_s1_adv;

    assign w_raddr_a = (rv32r_pkg::t_op'(s_axis_tuser) == rv32r_pkg::OP_READ)
                       ? s_axis_tdata[36:32] : s_axis_tdata[19:15];
    assign w_raddr_b = s_axis_tdata[24:20];

    assign w_wr.en   = w_alu_wr.en && w_s1_adv;
    assign w_wr.addr = w_alu_wr.addr;
    assign w_wr.data = w_alu_wr.data;

    rv32r_rf u_rf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s_fire),
        .i_raddr_a(w_raddr_a),
        .i_raddr_b(w_raddr_b),
        .i_wr     (w_wr),
        .o_rdata_a(w_a),
        .o_rdata_b(w_b)
    );

    rv32r_alu u_alu (
        .i_op        (r_s1_op),
        .i_instr     (r_s1_instr),
        .i_reg_index (r_s1_idx),
        .i_load_value(r_s1_lval),
        .i_a         (w_a),
        .i_b         (w_b),
        .o_res       (w_res),
        .o_wr        (w_alu_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (w_m_free) begin
                r_m_valid <= r_s1_valid;
            end
        end
        if (s_fire) begin
            r_s1_op    <= rv32r_pkg::t_op'(s_axis_tuser);
            r_s1_instr <= s_axis_tdata[31:0];
            r_s1_idx   <= s_axis_tdata[36:32];
            r_s1_lval  <= s_axis_tdata[68:37];
        end
        if (w_s1_adv) begin
            r_m_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'd0, r_m_res.dest, r_m_res.value};
    assign m_axis_tuser  = {r_m_res.illegal, r_m_res.wrote};

    `RV_ASSERT_NEXT(a_write_reported, w_wr.en,
        m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[36:32] == $past(w_wr.addr),
        "register write not reported by the next result")
    `RV_ASSERT_IMPL(a_stall_only_when_full, !s_axis_tready,
        r_s1_valid && m_axis_tvalid && !m_axis_tready,
        "input stalled while the pipeline can move")
    `RV_ASSERT_IMPL(a_illegal_clean, m_axis_tvalid && m_axis_tuser[1],
        !m_axis_tuser[0] && m_axis_tdata == '0,
        "illegal result carries a write or data")
    `RV_ASSERT(a_no_x0_write, !(w_wr.en && w_wr.addr == '0),
        "write to register zero")

endmodule

FILE: sim/tb_rv32i_r_type_execute.sv
// Testbench for the R-type execute unit: directed and random stream traffic checked by a predictor.
module tb_rv32i_r_type_execute;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int IDLE_PCT       = 14;
    localparam int QUIET_FIRST    = 500;
    localparam int QUIET_LAST     = 800;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 10;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] word;
        logic [4:0]  idx;
        logic [31:0] value;
        bit          drain;
    } t_request;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [rv32r_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [rv32r_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [rv32r_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [rv32r_pkg::OUT_USER_W-1:0] m_axis_tuser;

    t_request           instr_queue[$];
    rv32r_pkg::t_result writeback_queue[$];
    t_request           on_bus;
    logic [31:0]        shadow_rf [rv32r_pkg::NUM_REGS] = '{default: '0};
    int                 n_sent = 0;
    int                 n_received = 0;
    int                 n_errors = 0;
    int                 quiet_cycles = 0;

    rv32i_r_type_execute DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic rv32r_pkg::t_result predict_writeback(t_request rq);
        rv32r_pkg::t_result r;
        logic [6:0]  opcode;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [31:0] a;
        logic [31:0] b;
        bit          ok;
        r      = '0;
        opcode = rq.word[6:0];
        rd     = rq.word[11:7];
        f3     = rq.word[14:12];
        f7     = rq.word[31:25];
        a      = shadow_rf[rq.word[19:15]];
        b      = shadow_rf[rq.word[24:20]];
        sh     = b[4:0];
        ok     = 1'b1;
        case (rq.op)
            rv32r_pkg::OP_EXEC: begin
                if (opcode != rv32r_pkg::OPC_RTYPE) begin
                    ok = 1'b0;
                end else if (f7 == rv32r_pkg::F7_ALT) begin
                    if (f3 == rv32r_pkg::F3_ADD) r.value = a - b;
                    else if (f3 == rv32r_pkg::F3_SRL) r.value = $signed(a) >>> sh;
                    else ok = 1'b0;
                end else begin
                    case (f3)
                        rv32r_pkg::F3_ADD:  r.value = a + b;
                        rv32r_pkg::F3_SLL:  r.value = a << sh;
                        rv32r_pkg::F3_SLT:
                            r.value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                        rv32r_pkg::F3_SLTU: r.value = (a < b) ? 32'd1 : 32'd0;
                        rv32r_pkg::F3_XOR:  r.value = a ^ b;
                        rv32r_pkg::F3_SRL:  r.value = a >> sh;
                        rv32r_pkg::F3_OR:   r.value = a | b;
                        default:            r.value = a & b;
                    endcase
                end
                if (ok) begin
                    r.dest = rd;
                    if (rd != '0) begin
                        shadow_rf[rd] = r.value;
                        r.wrote       = 1'b1;
                    end
                end else begin
                    r.value   = '0;
                    r.illegal = 1'b1;
                end
            end
            rv32r_pkg::OP_LOAD: begin
                if (rq.idx != '0) begin
                    shadow_rf[rq.idx] = rq.value;
                    r.value           = rq.value;
                    r.dest            = rq.idx;
                    r.wrote           = 1'b1;
                end
            end
            rv32r_pkg::OP_READ: begin
                r.value = shadow_rf[rq.idx];
                r.dest  = rq.idx;
            end
            default: r.illegal = 1'b1;
        endcase
        return r;
    endfunction

    function automatic bit take_break();
        return (n_sent < QUIET_FIRST || n_sent >= QUIET_LAST) && $urandom_range(99) < IDLE_PCT;
    endfunction

    function automatic logic [31:0] r_word(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                           logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, rv32r_pkg::OPC_RTYPE};
    endfunction

    task automatic push_request(logic [1:0] op, logic [31:0] word, logic [4:0] idx,
                                logic [31:0] value, bit drain);
        t_request rq;
        rq.op    = op;
        rq.word  = word;
        rq.idx   = idx;
        rq.value = value;
        rq.drain = drain;
        instr_queue.push_back(rq);
    endtask

    task automatic push_exec(logic [31:0] word);
        push_request(rv32r_pkg::OP_EXEC, word, 5'($urandom), $urandom, 1'b0);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return 32'h8000_0000 >> $urandom_range(1) ^ {32{$urandom_range(1) == 1}};
            1: return $urandom_range(63);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        if (n_errors <= 40)
            $display("mismatch on result transfer %0d: %s got %h expected %h",
                     n_received, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                writeback_queue.push_back(predict_writeback(on_bus));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (instr_queue.size() != 0 && !take_break()
                        && !(instr_queue[0].drain && writeback_queue.size() != 0)) begin
                    on_bus = instr_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b000, on_bus.value, on_bus.idx, on_bus.word};
                    s_axis_tuser  <= on_bus.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        rv32r_pkg::t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !take_break();
            if (m_axis_tvalid && m_axis_tready) begin
                n_received++;
                if (writeback_queue.size() == 0) begin
                    report_mismatch("unexpected transfer, value", m_axis_tdata[31:0], '0);
                end else begin
                    want = writeback_queue.pop_front();
                    if (m_axis_tdata[31:0] !== want.value)
                        report_mismatch("result_value", m_axis_tdata[31:0], want.value);
                    if (m_axis_tdata[36:32] !== want.dest)
                        report_mismatch("dest_index", 32'(m_axis_tdata[36:32]),
                                        32'(want.dest));
                    if (m_axis_tuser[0] !== want.wrote)
                        report_mismatch("wrote_reg", 32'(m_axis_tuser[0]), 32'(want.wrote));
                    if (m_axis_tuser[1] !== want.illegal)
                        report_mismatch("illegal", 32'(m_axis_tuser[1]), 32'(want.illegal));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL rv32i_r_type_execute");
                $finish;
            end
        end
    end

    initial begin
        int          sel;
        logic [6:0]  f7;
        logic [1:0]  op;
        logic [31:0] word;

        push_request(rv32r_pkg::OP_LOAD, $urandom, 5'd1, 32'h8000_0000, 1'b0);
        push_request(rv32r_pkg::OP_LOAD, $urandom, 5'd2, 32'h7FFF_FFFF, 1'b0);
        push_request(rv32r_pkg::OP_LOAD, $urandom, 5'd3, 32'hFFFF_FFFF, 1'b0);
        push_request(rv32r_pkg::OP_LOAD, $urandom, 5'd4, 32'd33, 1'b0);
        push_request(rv32r_pkg::OP_LOAD, $urandom, 5'd0, 32'hDEAD_BEEF, 1'b0);
        push_request(rv32r_pkg::OP_READ, $urandom, 5'd0, $urandom, 1'b0);
        push_request(rv32r_pkg::OP_READ, $urandom, 5'd31, $urandom, 1'b0);
        push_request(rv32r_pkg::OP_READ, $urandom, 5'd1, $urandom, 1'b0);
        push_exec(r_word(7'h00, 5'd3, 5'd1, rv32r_pkg::F3_ADD, 5'd5));
        push_exec(r_word(rv32r_pkg::F7_ALT, 5'd2, 5'd1, rv32r_pkg::F3_ADD, 5'd6));
        push_exec(r_word(7'h00, 5'd4, 5'd3, rv32r_pkg::F3_SLL, 5'd7));
        push_exec(r_word(7'h00, 5'd2, 5'd1, rv32r_pkg::F3_SLT, 5'd8));
        push_exec(r_word(7'h00, 5'd2, 5'd1, rv32r_pkg::F3_SLTU, 5'd9));
        push_exec(r_word(7'h00, 5'd3, 5'd2, rv32r_pkg::F3_XOR, 5'd10));
        push_exec(r_word(7'h00, 5'd4, 5'd1, rv32r_pkg::F3_SRL, 5'd11));
        push_exec(r_word(rv32r_pkg::F7_ALT, 5'd4, 5'd1, rv32r_pkg::F3_SRL, 5'd12));
        push_exec(r_word(rv32r_pkg::F7_ALT, 5'd3, 5'd1, rv32r_pkg::F3_SRL, 5'd13));
        push_exec(r_word(7'h00, 5'd2, 5'd1, rv32r_pkg::F3_OR, 5'd14));
        push_exec(r_word(7'h00, 5'd2, 5'd3, rv32r_pkg::F3_AND, 5'd15));
        push_exec(r_word(7'h00, 5'd2, 5'd1, rv32r_pkg::F3_ADD, 5'd0));
        push_exec(32'hFFFF_FFFF);
        push_exec(32'h0000_0000);
        push_exec(r_word(rv32r_pkg::F7_ALT, 5'd2, 5'd1, rv32r_pkg::F3_SLL, 5'd16));
        push_exec(r_word(7'h7F, 5'd2, 5'd1, rv32r_pkg::F3_ADD, 5'd17));
        push_request(OP_UNKNOWN, $urandom, 5'($urandom), $urandom, 1'b0);
        push_request(rv32r_pkg::OP_READ, $urandom, 5'd13, $urandom, 1'b1);

        repeat (RANDOM_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 55) begin
                op = rv32r_pkg::OP_EXEC;
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: f7 = 7'h00;
                    5, 6, 7, 8:    f7 = rv32r_pkg::F7_ALT;
                    default:       f7 = 7'($urandom);
                endcase
                word = r_word(f7, 5'($urandom), 5'($urandom), 3'($urandom), 5'($urandom));
                if ($urandom_range(19) == 0) word = $urandom;
            end else begin
                if (sel < 75) op = rv32r_pkg::OP_LOAD;
                else if (sel < 95) op = rv32r_pkg::OP_READ;
                else op = OP_UNKNOWN;
                word = $urandom;
            end
            push_request(op, word, 5'($urandom), pick_value(), $urandom_range(199) == 0);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (instr_queue.size() != 0 || s_axis_tvalid || writeback_queue.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("PASS rv32i_r_type_execute");
        end else begin
            $display("FAIL rv32i_r_type_execute");
        end
        $finish;
    end

endmodule
